### hdl/qai_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qai_pkg
// Shared types and constants of the quaternion attitude integrator.
// ----------------------------------------------------------------------------
package qai_pkg;

   localparam logic [31:0] QAI_STEP_DT_RESET = 32'd42949673;
   localparam int QAI_FIFO_DEPTH = 4;
   localparam logic signed [31:0] QAI_ONE_Q30 = 32'sd1073741824;

   typedef struct packed {
      logic signed [31:0] q_w;
      logic signed [31:0] q_x;
      logic signed [31:0] q_y;
      logic signed [31:0] q_z;
      logic signed [31:0] rate_x;
      logic signed [31:0] rate_y;
      logic signed [31:0] rate_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_w;
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic               degenerate;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] w;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } vec_type;

   typedef struct packed {
      vec_type     p;
      logic [63:0] sum_sq;
   } mid_type;

endpackage
`default_nettype wire

### hdl/quaternion_attitude_integrator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_attitude_integrator_unit
// One Euler step of the quaternion kinematic equation, then renormalization.
// ----------------------------------------------------------------------------
// structure: 6 front stages, the queue, 33 square root and 62 reciprocal
// stages, 2 scaling stages and 1 result register
// throughput: one item per cycle while neither part is stalled; the front
// holds while its last stage is valid and the queue is full, and the whole
// back pipeline holds only while its result register is blocked
// reset clears all valid state and loads step_dt with its default
module quaternion_attitude_integrator_unit #(
   parameter int FIFO_DEPTH = qai_pkg::QAI_FIFO_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire qai_pkg::req_type req_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output qai_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic [31:0]      csr_wdata
);
   import qai_pkg::*;

   logic [31:0] step_dt_ff;
   logic        f_valid, q_full, q_valid, q_pop, r_valid;
   mid_type     f_data, q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_dt_ff <= QAI_STEP_DT_RESET;
      end else if (csr_we) begin
         step_dt_ff <= csr_wdata;
      end
   end

   qai_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_push   (req_push),
      .in_full   (req_full),
      .in_data   (req_data),
      .step_dt   (step_dt_ff),
      .out_valid (f_valid),
      .out_full  (q_full),
      .out_data  (f_data)
   );

   qai_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .full      (q_full),
      .push_data (f_data),
      .valid     (q_valid),
      .pop       (q_pop),
      .pop_data  (q_data)
   );

   qai_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_pop    (q_pop),
      .in_data   (q_data),
      .res_valid (r_valid),
      .res_take  (rsp_pop),
      .res_data  (rsp_data)
   );

   assign rsp_empty = !r_valid;

endmodule
`default_nettype wire

### hdl/qai_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qai_front
// Euler step: rate times orientation, scaling by half the time step,
// saturation and the sum of squares.
// ----------------------------------------------------------------------------
module qai_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_push,
   output logic                 in_full,
   input  wire qai_pkg::req_type in_data,
   input  wire logic [31:0]     step_dt,
   output logic                 out_valid,
   input  wire logic            out_full,
   output qai_pkg::mid_type     out_data
);
   import qai_pkg::*;

   localparam logic signed [49:0] PMAX = 50'sd2147483647;

   logic        adv;
   logic [5:0]  v_ff, v_in;

   logic signed [63:0] prod_ff [12];
   logic signed [63:0] prod_in [12];
   logic signed [31:0] q1_ff [4];
   logic signed [31:0] q1_in [4];

   logic [47:0]        mag2_ff [4];
   logic [47:0]        mag2_in [4];
   logic               neg2_ff [4];
   logic               neg2_in [4];
   logic signed [31:0] q2_ff [4];

   logic [47:0]        hi3_ff [4];
   logic [47:0]        hi3_in [4];
   logic [63:0]        lo3_ff [4];
   logic [63:0]        lo3_in [4];
   logic               neg3_ff [4];
   logic signed [31:0] q3_ff [4];

   logic signed [31:0] p4_ff [4];
   logic signed [31:0] p4_in [4];
   logic signed [31:0] p5_ff [4];
   logic [61:0]        sq5_ff [4];
   logic [61:0]        sq5_in [4];

   mid_type            out_ff, out_in;

   logic signed [47:0] t [12];
   logic signed [49:0] dq [4];
   logic [79:0]        tot [4];
   logic [46:0]        r4 [4];
   logic signed [49:0] qe [4];
   logic signed [49:0] re [4];
   logic signed [49:0] pe [4];
   logic [31:0]        a5 [4];

   assign adv       = !(v_ff[5] && out_full);
   assign in_full   = !adv;
   assign out_valid = v_ff[5];
   assign out_data  = out_ff;

   always_comb begin
      v_in = {v_ff[4:0], in_push && adv};

      prod_in[0]  = in_data.rate_x * in_data.q_x;
      prod_in[1]  = in_data.rate_y * in_data.q_y;
      prod_in[2]  = in_data.rate_z * in_data.q_z;
      prod_in[3]  = in_data.rate_x * in_data.q_w;
      prod_in[4]  = in_data.rate_y * in_data.q_z;
      prod_in[5]  = in_data.rate_z * in_data.q_y;
      prod_in[6]  = in_data.rate_x * in_data.q_z;
      prod_in[7]  = in_data.rate_y * in_data.q_w;
      prod_in[8]  = in_data.rate_z * in_data.q_x;
      prod_in[9]  = in_data.rate_x * in_data.q_y;
      prod_in[10] = in_data.rate_y * in_data.q_x;
      prod_in[11] = in_data.rate_z * in_data.q_w;
      q1_in[0] = in_data.q_w;
      q1_in[1] = in_data.q_x;
      q1_in[2] = in_data.q_y;
      q1_in[3] = in_data.q_z;

      // floor shift by 16
      for (int k = 0; k < 12; k++) begin
         t[k] = $signed(prod_ff[k][63:16]);
      end
      dq[0] = -50'(t[0]) - 50'(t[1]) - 50'(t[2]);
      dq[1] =  50'(t[3]) + 50'(t[4]) - 50'(t[5]);
      dq[2] = -50'(t[6]) + 50'(t[7]) + 50'(t[8]);
      dq[3] =  50'(t[9]) - 50'(t[10]) + 50'(t[11]);

      for (int k = 0; k < 4; k++) begin
         neg2_in[k] = dq[k][49];
         mag2_in[k] = dq[k][49] ? 48'(-dq[k]) : dq[k][47:0];

         hi3_in[k] = mag2_ff[k][47:32] * step_dt;
         lo3_in[k] = mag2_ff[k][31:0] * step_dt;

         tot[k] = {hi3_ff[k], 32'd0} + {16'd0, lo3_ff[k]};
         r4[k]  = tot[k][79:33];
         qe[k]  = 50'(q3_ff[k]);
         re[k]  = $signed({3'b000, r4[k]});
         if (neg3_ff[k]) begin
            re[k] = -re[k];
         end
         pe[k] = qe[k] + re[k];
         if (pe[k] > PMAX) begin
            p4_in[k] = PMAX[31:0];
         end else if (pe[k] < -PMAX) begin
            p4_in[k] = -PMAX[31:0];
         end else begin
            p4_in[k] = pe[k][31:0];
         end

         a5[k]     = p4_ff[k][31] ? -p4_ff[k] : p4_ff[k];
         sq5_in[k] = a5[k][30:0] * a5[k][30:0];
      end

      out_in.p.w    = p5_ff[0];
      out_in.p.x    = p5_ff[1];
      out_in.p.y    = p5_ff[2];
      out_in.p.z    = p5_ff[3];
      out_in.sum_sq = 64'(sq5_ff[0]) + 64'(sq5_ff[1]) + 64'(sq5_ff[2])
                    + 64'(sq5_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         q1_ff   <= q1_in;
         mag2_ff <= mag2_in;
         neg2_ff <= neg2_in;
         q2_ff   <= q1_ff;
         hi3_ff  <= hi3_in;
         lo3_ff  <= lo3_in;
         neg3_ff <= neg2_ff;
         q3_ff   <= q2_ff;
         p4_ff   <= p4_in;
         p5_ff   <= p4_ff;
         sq5_ff  <= sq5_in;
         out_ff  <= out_in;
      end
   end

endmodule
`default_nettype wire

### hdl/qai_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qai_fifo
// Short queue between the front and back parts.
// ----------------------------------------------------------------------------
module qai_fifo #(
   parameter int DEPTH = qai_pkg::QAI_FIFO_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire qai_pkg::mid_type push_data,
   output logic                  valid,
   input  wire logic             pop,
   output qai_pkg::mid_type      pop_data
);
   import qai_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   mid_type         mem_ff [DEPTH];
   logic [AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            do_push, do_pop;

   assign full     = (cnt_ff == CW'(DEPTH));
   assign valid    = (cnt_ff != '0);
   assign pop_data = mem_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

### hdl/qai_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qai_back
// Normalization: pipelined square root, pipelined reciprocal, scaling and
// the result register; a zero sum of squares yields the identity quaternion.
// ----------------------------------------------------------------------------
module qai_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_pop,
   input  wire qai_pkg::mid_type in_data,
   output logic                  res_valid,
   input  wire logic             res_take,
   output qai_pkg::rsp_type      res_data
);
   import qai_pkg::*;

   localparam int SQ_N = 32;
   localparam int DV_N = 61;

   logic adv;

   logic               sq_v_ff    [SQ_N+1];
   logic [63:0]        sq_x_ff    [SQ_N+1];
   logic [63:0]        sq_x_in    [SQ_N+1];
   logic [33:0]        sq_rem_ff  [SQ_N+1];
   logic [33:0]        sq_rem_in  [SQ_N+1];
   logic [31:0]        sq_root_ff [SQ_N+1];
   logic [31:0]        sq_root_in [SQ_N+1];
   vec_type            sq_p_ff    [SQ_N+1];
   logic               sq_deg_ff  [SQ_N+1];

   logic               dv_v_ff    [DV_N+1];
   logic [31:0]        dv_l_ff    [DV_N+1];
   logic [31:0]        dv_rem_ff  [DV_N+1];
   logic [31:0]        dv_rem_in  [DV_N+1];
   logic [60:0]        dv_q_ff    [DV_N+1];
   logic [60:0]        dv_q_in    [DV_N+1];
   vec_type            dv_p_ff    [DV_N+1];
   logic               dv_deg_ff  [DV_N+1];

   logic               m1_v_ff, m2_v_ff, slot_v_ff, slot_v_in;
   logic [61:0]        m1_lo_ff [4];
   logic [61:0]        m1_lo_in [4];
   logic [60:0]        m1_hi_ff [4];
   logic [60:0]        m1_hi_in [4];
   logic               m1_neg_ff [4];
   logic               m1_neg_in [4];
   logic               m1_deg_ff;
   rsp_type            m2_ff, m2_in, slot_ff;

   logic [35:0]        sq_sh  [SQ_N];
   logic [35:0]        sq_try [SQ_N];
   logic [32:0]        dv_sh  [DV_N];
   logic signed [31:0] pc [4];
   logic [31:0]        am [4];
   logic [92:0]        tot [4];
   logic [31:0]        rr [4];
   logic signed [31:0] ov [4];
   logic               load;

   assign adv       = !(m2_v_ff && slot_v_ff && !res_take);
   assign in_pop    = adv && in_valid;
   assign load      = m2_v_ff && (!slot_v_ff || res_take);
   assign res_valid = slot_v_ff;
   assign res_data  = slot_ff;

   always_comb begin
      sq_x_in[0]    = in_data.sum_sq;
      sq_rem_in[0]  = '0;
      sq_root_in[0] = '0;
      for (int k = 0; k < SQ_N; k++) begin
         sq_sh[k]  = {sq_rem_ff[k], sq_x_ff[k][63:62]};
         sq_try[k] = {2'b00, sq_root_ff[k], 2'b01};
         sq_x_in[k+1] = {sq_x_ff[k][61:0], 2'b00};
         if (sq_sh[k] >= sq_try[k]) begin
            sq_rem_in[k+1]  = 34'(sq_sh[k] - sq_try[k]);
            sq_root_in[k+1] = {sq_root_ff[k][30:0], 1'b1};
         end else begin
            sq_rem_in[k+1]  = sq_sh[k][33:0];
            sq_root_in[k+1] = {sq_root_ff[k][30:0], 1'b0};
         end
      end

      dv_rem_in[0] = '0;
      dv_q_in[0]   = '0;
      for (int k = 0; k < DV_N; k++) begin
         dv_sh[k] = {dv_rem_ff[k], (k == 0)};
         if (dv_sh[k] >= {1'b0, dv_l_ff[k]}) begin
            dv_rem_in[k+1] = 32'(dv_sh[k] - {1'b0, dv_l_ff[k]});
            dv_q_in[k+1]   = {dv_q_ff[k][59:0], 1'b1};
         end else begin
            dv_rem_in[k+1] = dv_sh[k][31:0];
            dv_q_in[k+1]   = {dv_q_ff[k][59:0], 1'b0};
         end
      end

      pc[0] = dv_p_ff[DV_N].w;
      pc[1] = dv_p_ff[DV_N].x;
      pc[2] = dv_p_ff[DV_N].y;
      pc[3] = dv_p_ff[DV_N].z;
      for (int k = 0; k < 4; k++) begin
         m1_neg_in[k] = pc[k][31];
         am[k]        = pc[k][31] ? -pc[k] : pc[k];
         m1_lo_in[k]  = am[k][30:0] * dv_q_ff[DV_N][30:0];
         m1_hi_in[k]  = am[k][30:0] * dv_q_ff[DV_N][60:31];
         tot[k] = {1'b0, m1_hi_ff[k], 31'd0} + {31'd0, m1_lo_ff[k]};
         rr[k]  = tot[k][61:30];
         ov[k]  = m1_neg_ff[k] ? -$signed(rr[k]) : $signed(rr[k]);
      end

      if (m1_deg_ff) begin
         m2_in.out_w = QAI_ONE_Q30;
         m2_in.out_x = '0;
         m2_in.out_y = '0;
         m2_in.out_z = '0;
      end else begin
         m2_in.out_w = ov[0];
         m2_in.out_x = ov[1];
         m2_in.out_y = ov[2];
         m2_in.out_z = ov[3];
      end
      m2_in.degenerate = m1_deg_ff;

      slot_v_in = slot_v_ff;
      if (load) begin
         slot_v_in = 1'b1;
      end else if (res_take) begin
         slot_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= SQ_N; k++) begin
            sq_v_ff[k] <= 1'b0;
         end
         for (int k = 0; k <= DV_N; k++) begin
            dv_v_ff[k] <= 1'b0;
         end
         m1_v_ff   <= 1'b0;
         m2_v_ff   <= 1'b0;
         slot_v_ff <= 1'b0;
      end else begin
         if (adv) begin
            sq_v_ff[0] <= in_pop;
            for (int k = 0; k < SQ_N; k++) begin
               sq_v_ff[k+1] <= sq_v_ff[k];
            end
            dv_v_ff[0] <= sq_v_ff[SQ_N];
            for (int k = 0; k < DV_N; k++) begin
               dv_v_ff[k+1] <= dv_v_ff[k];
            end
            m1_v_ff <= dv_v_ff[DV_N];
            m2_v_ff <= m1_v_ff;
         end
         slot_v_ff <= slot_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_x_ff    <= sq_x_in;
         sq_rem_ff  <= sq_rem_in;
         sq_root_ff <= sq_root_in;
         sq_p_ff[0]   <= in_data.p;
         sq_deg_ff[0] <= (in_data.sum_sq == '0);
         for (int k = 0; k < SQ_N; k++) begin
            sq_p_ff[k+1]   <= sq_p_ff[k];
            sq_deg_ff[k+1] <= sq_deg_ff[k];
         end
         dv_rem_ff    <= dv_rem_in;
         dv_q_ff      <= dv_q_in;
         dv_l_ff[0]   <= sq_root_ff[SQ_N];
         dv_p_ff[0]   <= sq_p_ff[SQ_N];
         dv_deg_ff[0] <= sq_deg_ff[SQ_N];
         for (int k = 0; k < DV_N; k++) begin
            dv_l_ff[k+1]   <= dv_l_ff[k];
            dv_p_ff[k+1]   <= dv_p_ff[k];
            dv_deg_ff[k+1] <= dv_deg_ff[k];
         end
         m1_lo_ff  <= m1_lo_in;
         m1_hi_ff  <= m1_hi_in;
         m1_neg_ff <= m1_neg_in;
         m1_deg_ff <= dv_deg_ff[DV_N];
         m2_ff     <= m2_in;
      end
      if (load) begin
         slot_ff <= m2_ff;
      end
   end

endmodule
`default_nettype wire
